@@ sv/edd_pkg.sv @@
// ----------------------------------------------------------------------------
// edd_pkg
// Shared constants and types for the error diffusion dither block.
// ----------------------------------------------------------------------------
package edd_pkg;

	// default build-time settings
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int FRAC_BITS_DEF = 4;

	// field widths
	localparam int PIX_W      = 8;
	localparam int IMG_W_W    = 11;
	localparam int THR_W      = 12;
	localparam int CFG_DATA_W = 12;

	// error weights are in sixteenths
	localparam int WEIGHT_SHIFT = 4;

	// register reset values
	localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd1024;
	localparam logic [THR_W-1:0]   THR_RST   = 12'd2040;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH = 1'b0,
		REG_THRESHOLD   = 1'b1
	} cfg_reg_t;

endpackage

@@ sv/edd_ram.sv @@
// ----------------------------------------------------------------------------
// edd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module edd_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/edd_chan.sv @@
// ----------------------------------------------------------------------------
// edd_chan
// One color channel: accumulate diffused error, quantize to one bit and split
// the quantization error into its right and below-row shares.
// ----------------------------------------------------------------------------
module edd_chan #(
	parameter int FRAC_BITS = edd_pkg::FRAC_BITS_DEF
) (
	input  logic [edd_pkg::PIX_W-1:0]  pix,
	input  logic [edd_pkg::THR_W-1:0]  threshold,
	input  logic                       use_line,
	input  logic signed [FRAC_BITS+9:0] right_carry,
	input  logic signed [FRAC_BITS+9:0] line_err,
	input  logic signed [FRAC_BITS+9:0] below_part,
	input  logic signed [FRAC_BITS+9:0] below_right_part,
	output logic                       bit_out,
	output logic signed [FRAC_BITS+9:0] right_new,
	output logic signed [FRAC_BITS+9:0] below_left_new,
	output logic signed [FRAC_BITS+9:0] below_new,
	output logic signed [FRAC_BITS+9:0] below_right_new
);

	import edd_pkg::*;

	localparam int ACC_W = FRAC_BITS + 10;
	localparam int SUM_W = ACC_W + 4;

	// clamp a wide sum to the accumulator range
	function automatic logic signed [ACC_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){v[SUM_W-1]}}) begin
			r = v[ACC_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ACC_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext(input logic signed [ACC_W-1:0] v);
		return $signed({{(SUM_W-ACC_W){v[ACC_W-1]}}, v});
	endfunction

	logic signed [SUM_W-1:0] pix_fx;
	logic signed [SUM_W-1:0] line_term;
	logic signed [SUM_W-1:0] sum_raw;
	logic signed [ACC_W-1:0] acc;
	logic signed [SUM_W-1:0] acc_ext;
	logic signed [SUM_W-1:0] thr_ext;
	logic signed [SUM_W-1:0] full_ext;
	logic signed [SUM_W-1:0] err;
	logic signed [SUM_W-1:0] p7;
	logic signed [SUM_W-1:0] p3;
	logic signed [SUM_W-1:0] p5;

	// pixel in fixed point plus incoming errors
	assign pix_fx    = $signed({{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, pix, {FRAC_BITS{1'b0}}});
	assign line_term = use_line ? ext(line_err) : '0;
	assign sum_raw   = pix_fx + ext(right_carry) + line_term;
	assign acc       = sat(sum_raw);
	assign acc_ext   = ext(acc);

	// quantize against the threshold
	assign thr_ext = $signed({{(SUM_W-THR_W){1'b0}}, threshold});
	assign bit_out = acc_ext > thr_ext;

	// quantization error
	assign full_ext = $signed({{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, {PIX_W{1'b1}},
		{FRAC_BITS{1'b0}}});
	assign err      = acc_ext - (bit_out ? full_ext : '0);

	// weighted shares, floored by arithmetic shift
	assign p7 = (err <<< 3) - err;
	assign p3 = (err <<< 1) + err;
	assign p5 = (err <<< 2) + err;

	assign right_new       = sat(p7 >>> WEIGHT_SHIFT);
	assign below_left_new  = sat(ext(below_part) + (p3 >>> WEIGHT_SHIFT));
	assign below_new       = sat(ext(below_right_part) + (p5 >>> WEIGHT_SHIFT));
	assign below_right_new = sat(err >>> WEIGHT_SHIFT);

endmodule

@@ sv/error_diffusion_dither_top.sv @@
// ----------------------------------------------------------------------------
// error_diffusion_dither_top
// Floyd-Steinberg dithering of a raster RGB stream down to one bit per color.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid / in_stall   | red, green, blue, frame_start
//   out     | output    | out_valid / out_stall | out_red, out_green, out_blue
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per clock sustained while the output is not stalled; a pixel taken
// into the input register fires into the result register, which drives the
// outputs, as soon as that register is empty or being accepted.
// The line buffer RAM has one write port; the extra below write at a row end
// is held until the write port is free and forwarded to the read path until it
// lands. Reset clears control, configuration and carry registers; the line
// buffer needs no clearing pass. A stalled output holds its result while one
// more pixel waits in the input register; cfg_ready is always high.
// ----------------------------------------------------------------------------
module error_diffusion_dither_top #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF,
	parameter int FRAC_BITS = edd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [edd_pkg::PIX_W-1:0]     red,
	input  logic [edd_pkg::PIX_W-1:0]     green,
	input  logic [edd_pkg::PIX_W-1:0]     blue,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          out_red,
	output logic                          out_green,
	output logic                          out_blue,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  edd_pkg::cfg_reg_t             cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0] cfg_data
);

	import edd_pkg::*;

	localparam int ACC_W  = FRAC_BITS + 10;
	localparam int LINE_W = 3 * ACC_W;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WCMP_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

	// configuration registers
	logic [IMG_W_W-1:0] width_q;
	logic [THR_W-1:0]   thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMG_W_RST;
			thr_q   <= THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[IMG_W_W-1:0];
				REG_THRESHOLD:   thr_q   <= cfg_data[THR_W-1:0];
				default:         ;
			endcase
		end
	end

	// input register
	logic               v_s1;
	logic [PIX_W-1:0]   pix_s1 [3];
	logic               fs_s1;
	logic               fire;
	logic               in_acc;
	logic               out_valid_q;
	logic [2:0]         res_q;

	assign fire     = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && !fire;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1[0] <= red;
			pix_s1[1] <= green;
			pix_s1[2] <= blue;
			fs_s1     <= frame_start;
		end
	end

	// row state
	logic [COL_W-1:0]        col_q;
	logic                    first_q;
	logic signed [ACC_W-1:0] rc_q  [3];
	logic signed [ACC_W-1:0] bp_q  [3];
	logic signed [ACC_W-1:0] brp_q [3];

	// frame start clears row state ahead of the pixel
	logic [COL_W-1:0]  col_eff;
	logic              first_eff;
	logic [WCMP_W-1:0] w_ext;
	logic [WCMP_W-1:0] w_eff;
	logic [WCMP_W-1:0] col_inc;
	logic              last;
	logic [COL_W-1:0]  col_next;

	assign col_eff   = fs_s1 ? '0 : col_q;
	assign first_eff = fs_s1 || first_q;

	// effective width, clamped to one .. MAX_WIDTH
	assign w_ext = WCMP_W'(width_q);
	always_comb begin
		if (w_ext == '0) begin
			w_eff = WCMP_W'(1);
		end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WCMP_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
	end

	assign col_inc  = WCMP_W'(col_eff) + WCMP_W'(1);
	assign last     = col_inc >= w_eff;
	assign col_next = last ? '0 : col_inc[COL_W-1:0];

	// line buffer read path with forwarding of recent writes
	logic              ram_we;
	logic [COL_W-1:0]  ram_waddr;
	logic [LINE_W-1:0] ram_wdata;
	logic [COL_W-1:0]  ram_raddr;
	logic [LINE_W-1:0] ram_rdata;
	logic              hit_q;
	logic [LINE_W-1:0] byp_q;
	logic              pend_v_q;
	logic [COL_W-1:0]  pend_addr_q;
	logic [LINE_W-1:0] pend_data_q;
	logic [LINE_W-1:0] line_rd;
	logic              prim_we;
	logic [LINE_W-1:0] bl_word;
	logic [LINE_W-1:0] nb_word;

	assign ram_raddr = fire ? col_next : col_q;

	always_comb begin
		if (pend_v_q && pend_addr_q == col_q) begin
			line_rd = pend_data_q;
		end else if (hit_q) begin
			line_rd = byp_q;
		end else begin
			line_rd = ram_rdata;
		end
	end

	// channel datapaths
	logic                    bit_c   [3];
	logic signed [ACC_W-1:0] rc_new  [3];
	logic signed [ACC_W-1:0] bl_new  [3];
	logic signed [ACC_W-1:0] nb_new  [3];
	logic signed [ACC_W-1:0] brp_new [3];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		edd_chan #(
			.FRAC_BITS(FRAC_BITS)
		) u_chan (
			.pix             (pix_s1[c]),
			.threshold       (thr_q),
			.use_line        (!first_eff),
			.right_carry     (fs_s1 ? '0 : rc_q[c]),
			.line_err        ($signed(line_rd[c*ACC_W +: ACC_W])),
			.below_part      (fs_s1 ? '0 : bp_q[c]),
			.below_right_part(fs_s1 ? '0 : brp_q[c]),
			.bit_out         (bit_c[c]),
			.right_new       (rc_new[c]),
			.below_left_new  (bl_new[c]),
			.below_new       (nb_new[c]),
			.below_right_new (brp_new[c])
		);

		assign bl_word[c*ACC_W +: ACC_W] = bl_new[c];
		assign nb_word[c*ACC_W +: ACC_W] = nb_new[c];

		// per-channel carries
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rc_q[c]  <= '0;
				bp_q[c]  <= '0;
				brp_q[c] <= '0;
			end else if (fire) begin
				rc_q[c]  <= last ? '0 : rc_new[c];
				bp_q[c]  <= last ? '0 : nb_new[c];
				brp_q[c] <= last ? '0 : brp_new[c];
			end
		end
	end

	// write port: below-left entry first, held row-end entry otherwise
	assign prim_we   = fire && (col_eff != '0);
	assign ram_we    = prim_we || pend_v_q;
	assign ram_waddr = prim_we ? col_eff - COL_W'(1) : pend_addr_q;
	assign ram_wdata = prim_we ? bl_word : pend_data_q;

	edd_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// forwarding registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			hit_q <= ram_we && (ram_waddr == ram_raddr);
			if (fire && last) begin
				pend_v_q <= 1'b1;
			end else if (!prim_we) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_q <= ram_wdata;
		if (fire && last) begin
			pend_addr_q <= col_eff;
			pend_data_q <= nb_word;
		end
	end

	// column and first-row tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (fire) begin
			col_q   <= col_next;
			first_q <= last ? 1'b0 : first_eff;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= {bit_c[2], bit_c[1], bit_c[0]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = res_q[0];
	assign out_green = res_q[1];
	assign out_blue  = res_q[2];

endmodule
